### sv/bec_pkg.sv
// Shared types and constants for the byte escape codec.
// Used by bec_engine and byte_escape_codec_unit; depends on nothing.
`default_nettype none

package bec_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVOID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE = 3'd4;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ILLEGAL   = 2'd1,
        ERR_TRUNCATED = 2'd2
    } err_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              run_end;
        err_t              error_code;
    } result_t;

endpackage

`default_nettype wire

### sv/bec_engine.sv
// Per-byte escape/unescape logic with the decode state bits.
// Depends on bec_pkg; instantiated by byte_escape_codec_unit.
`default_nettype none

module bec_engine #(
    parameter int unsigned MAX_PAIRS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 consume,
    input  wire logic                                 mode,
    input  wire logic [bec_pkg::BYTE_W-1:0]           escape_byte,
    input  wire logic [bec_pkg::COUNT_W-1:0]          pair_count,
    input  wire logic [MAX_PAIRS-1:0][bec_pkg::BYTE_W-1:0] avoid_table,
    input  wire logic [MAX_PAIRS-1:0][bec_pkg::BYTE_W-1:0] replace_table,
    input  wire logic [bec_pkg::BYTE_W-1:0]           in_byte,
    input  wire logic                                 in_last,
    output logic [1:0]                                result_count,
    output bec_pkg::result_t                          result0,
    output bec_pkg::result_t                          result1
);

    logic escape_pending_reg;
    logic escape_pending_next;
    logic discarding_reg;
    logic discarding_next;
    logic [MAX_PAIRS-1:0] avoid_hit;
    logic [MAX_PAIRS-1:0] replace_hit;
    logic [bec_pkg::BYTE_W-1:0] replace_sel;
    logic [bec_pkg::BYTE_W-1:0] avoid_sel;

    // The descending scan leaves the lowest matching entry selected.
    always_comb
    begin
        replace_sel = '0;
        avoid_sel   = '0;
        for (int k = 0; k < MAX_PAIRS; k++)
        begin
            avoid_hit[k]   = (bec_pkg::COUNT_W'(k) < pair_count) &&
                             (avoid_table[k] == in_byte);
            replace_hit[k] = (bec_pkg::COUNT_W'(k) < pair_count) &&
                             (replace_table[k] == in_byte);
        end
        for (int k = MAX_PAIRS - 1; k >= 0; k--)
        begin
            if (avoid_hit[k])
            begin
                replace_sel = replace_table[k];
            end
            if (replace_hit[k])
            begin
                avoid_sel = avoid_table[k];
            end
        end
    end

    always_comb
    begin
        result_count        = 2'd0;
        result0             = '0;
        result1             = '0;
        escape_pending_next = escape_pending_reg;
        discarding_next     = discarding_reg;
        if (mode == bec_pkg::MODE_ENCODE)
        begin
            escape_pending_next = 1'b0;
            discarding_next     = 1'b0;
            if (in_byte == escape_byte)
            begin
                result_count = 2'd2;
                result0 = '{escape_byte, 1'b0, 1'b0, bec_pkg::ERR_NONE};
                result1 = '{escape_byte, in_last, 1'b1, bec_pkg::ERR_NONE};
            end
            else if (|avoid_hit)
            begin
                result_count = 2'd2;
                result0 = '{escape_byte, 1'b0, 1'b0, bec_pkg::ERR_NONE};
                result1 = '{replace_sel, in_last, 1'b1, bec_pkg::ERR_NONE};
            end
            else
            begin
                result_count = 2'd1;
                result0 = '{in_byte, in_last, 1'b1, bec_pkg::ERR_NONE};
            end
        end
        else if (discarding_reg)
        begin
            if (in_last)
            begin
                discarding_next = 1'b0;
            end
        end
        else if (escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            result_count        = 2'd1;
            if (in_byte == escape_byte)
            begin
                result0 = '{escape_byte, in_last, 1'b1, bec_pkg::ERR_NONE};
            end
            else if (|replace_hit)
            begin
                result0 = '{avoid_sel, in_last, 1'b1, bec_pkg::ERR_NONE};
            end
            else
            begin
                discarding_next = !in_last;
                result0 = '{'0, 1'b1, 1'b1, bec_pkg::ERR_ILLEGAL};
            end
        end
        else if (in_byte == escape_byte)
        begin
            if (in_last)
            begin
                result_count = 2'd1;
                result0 = '{'0, 1'b1, 1'b1, bec_pkg::ERR_TRUNCATED};
            end
            else
            begin
                escape_pending_next = 1'b1;
            end
        end
        else
        begin
            result_count = 2'd1;
            result0 = '{in_byte, in_last, 1'b1, bec_pkg::ERR_NONE};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            discarding_reg     <= 1'b0;
        end
        else if (consume)
        begin
            escape_pending_reg <= escape_pending_next;
            discarding_reg     <= discarding_next;
        end
    end

endmodule

`default_nettype wire

### sv/byte_escape_codec_unit.sv
// Top level of the byte escape codec: configuration registers, input stage and result queue.
// Depends on bec_pkg and bec_engine.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | in_byte, in_last
//  output  | out_valid / out_ready| out_byte, out_last, run_end, error_code
//  config  | cfg_we (no wait)     | cfg_index, cfg_data
//
// A byte waits in the input stage until the result queue is empty, or holds one entry
// that is being taken; its results are then written into the queue. A doubled byte fills
// both entries of the two-entry result queue that feeds the single output port.
// Back-pressure on the output holds the queue and then the input stage.
// Reset clears the configuration to its defaults, the decode state and all valid flags.
`default_nettype none

module byte_escape_codec_unit #(
    parameter int unsigned MAX_PAIRS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [bec_pkg::BYTE_W-1:0]       in_byte,
    input  wire logic                             in_last,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [bec_pkg::BYTE_W-1:0]            out_byte,
    output logic                                  out_last,
    output logic                                  run_end,
    output logic [1:0]                            error_code,
    input  wire logic                             cfg_we,
    input  wire logic [bec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bec_pkg::CFG_W-1:0]        cfg_data
);

    localparam int unsigned TABLE_W = MAX_PAIRS * bec_pkg::BYTE_W;

    logic                                           mode_reg;
    logic [bec_pkg::BYTE_W-1:0]                     escape_reg;
    logic [bec_pkg::COUNT_W-1:0]                    count_reg;
    logic [MAX_PAIRS-1:0][bec_pkg::BYTE_W-1:0]      avoid_reg;
    logic [MAX_PAIRS-1:0][bec_pkg::BYTE_W-1:0]      replace_reg;

    logic                                           stage_valid_reg;
    logic [bec_pkg::BYTE_W-1:0]                     stage_byte_reg;
    logic                                           stage_last_reg;

    logic [1:0]                                     fill_reg;
    bec_pkg::result_t                               slot0_reg;
    bec_pkg::result_t                               slot1_reg;

    logic                                           pop;
    logic                                           advance;
    logic [1:0]                                     result_count;
    bec_pkg::result_t                               result0;
    bec_pkg::result_t                               result1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= bec_pkg::MODE_ENCODE;
            escape_reg  <= bec_pkg::ESCAPE_RESET;
            count_reg   <= '0;
            avoid_reg   <= '0;
            replace_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bec_pkg::REG_MODE:    mode_reg    <= cfg_data[0];
                bec_pkg::REG_ESCAPE:  escape_reg  <= cfg_data[bec_pkg::BYTE_W-1:0];
                bec_pkg::REG_COUNT:   count_reg   <= cfg_data[bec_pkg::COUNT_W-1:0];
                bec_pkg::REG_AVOID:   avoid_reg   <= cfg_data[TABLE_W-1:0];
                bec_pkg::REG_REPLACE: replace_reg <= cfg_data[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign pop      = out_valid && out_ready;
    assign advance  = stage_valid_reg && ((fill_reg == 2'd0) || ((fill_reg == 2'd1) && pop));
    assign in_ready = !stage_valid_reg || advance;

    bec_engine #(
        .MAX_PAIRS(MAX_PAIRS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .consume      (advance),
        .mode         (mode_reg),
        .escape_byte  (escape_reg),
        .pair_count   (count_reg),
        .avoid_table  (avoid_reg),
        .replace_table(replace_reg),
        .in_byte      (stage_byte_reg),
        .in_last      (stage_last_reg),
        .result_count (result_count),
        .result0      (result0),
        .result1      (result1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_byte_reg <= in_byte;
            stage_last_reg <= in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else if (advance)
        begin
            fill_reg <= result_count;
        end
        else if (pop)
        begin
            fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot0_reg <= result0;
            slot1_reg <= result1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign out_valid  = (fill_reg != 2'd0);
    assign out_byte   = slot0_reg.data;
    assign out_last   = slot0_reg.last;
    assign run_end    = slot0_reg.run_end;
    assign error_code = slot0_reg.error_code;

endmodule

`default_nettype wire
